/* hdl/mlfq_pkg.sv */
// Shared types, field widths and a helper function for the multilevel feedback scheduler.
// Depends on nothing; mlfq_pick and the core refer to it by scoped names.
package mlfq_pkg;

    // Fixed field widths of the beat payloads and of the slot record.
    localparam int ID_W        = 4;
    localparam int SERVICE_W   = 16;
    localparam int STAMP_W     = 32;
    localparam int RUN_LEVEL_W = 3;
    localparam int QUANT_W     = 8;
    localparam int LEVEL_ARG_W = 4;

    // Control from the sequencer to the shared compare unit.
    typedef struct packed {
        logic clear;
        logic live;
    } pick_ctl_t;

    // Length of the quantum granted at a given level.
    function automatic logic [QUANT_W-1:0] quantum_for(input logic mode,
                                                      input logic [LEVEL_ARG_W-1:0] level);
        logic [QUANT_W-1:0] q;
        if (!mode) begin
            q = QUANT_W'(1);
        end else if (level > LEVEL_ARG_W'(7)) begin
            q = {QUANT_W{1'b1}};
        end else begin
            q = QUANT_W'(1) << level[2:0];
        end
        return q;
    endfunction

endpackage

/* hdl/mlfq_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/mlfq_pick.sv */
// Shared compare unit: keeps the best ready slot seen during a scan (lowest level,
// then earliest stamp, then lowest slot). Depends on mlfq_pkg.
module mlfq_pick #(
    parameter int SW = 4,
    parameter int LW = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlfq_pkg::pick_ctl_t           ctl,
    input  logic [SW-1:0]                 cand_idx,
    input  logic [LW-1:0]                 cand_level,
    input  logic [mlfq_pkg::STAMP_W-1:0]  cand_stamp,
    output logic                          found,
    output logic [SW-1:0]                 best_idx,
    output logic [LW-1:0]                 best_level
);

    logic                         found_reg, found_next;
    logic [SW-1:0]                best_idx_reg, best_idx_next;
    logic [LW-1:0]                best_level_reg, best_level_next;
    logic [mlfq_pkg::STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic                         better;

    // The candidate wins only when strictly better, so the lower slot keeps ties.
    assign better = !found_reg || (cand_level < best_level_reg) ||
                    ((cand_level == best_level_reg) && (cand_stamp < best_stamp_reg));

    always_comb begin
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_level_next = best_level_reg;
        best_stamp_next = best_stamp_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
        end else if (ctl.live && better) begin
            found_next      = 1'b1;
            best_idx_next   = cand_idx;
            best_level_next = cand_level;
            best_stamp_next = cand_stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    // The best record itself needs no reset; found qualifies it.
    always_ff @(posedge aclk) begin
        best_idx_reg   <= best_idx_next;
        best_level_reg <= best_level_next;
        best_stamp_reg <= best_stamp_next;
    end

    assign found      = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_level = best_level_reg;

endmodule

/* hdl/multilevel_feedback_scheduler_core.sv */
// Top level of the multilevel feedback scheduler: tick sequencer, slot record RAM and
// busy bits. Depends on mlfq_pkg, mlfq_ram and mlfq_pick.
//
// Usage: every beat on the s_ channel is one time tick, optionally carrying one
// arriving job (slot id and service time). Every tick yields exactly one beat on the
// m_ channel: the job that ran (or an idle tick), its level, whether it finished, the
// tick count after the tick, and whether the arrival was rejected.
// quantum_mode is written through cfg_wr_en/cfg_wr_data while no tick is in flight.
// Steps: a tick that keeps its current holder reads its record (S_RUN_RD), runs it
// (S_RUN) and loads the result (S_OUT). A tick that must pick a new holder first
// releases an old holder whose quantum has run out, then scans the slot records one
// per cycle through the single RAM read port and the shared compare unit and grants
// the best. One tick is processed at a time; s_ready is high only between ticks,
// from the cycle after the result is loaded.
// The result sits in an output register, so the next tick is accepted while it
// waits; a stalled receiver holds the following tick at its final step.
// Reset: all slots free, no holder, tick count zero, quantum_mode zero. The record
// RAM needs no clearing, since a record is used only while its busy bit is set.
module multilevel_feedback_scheduler_core #(
    parameter int SLOTS     = 16,
    parameter int MAX_LEVEL = 7
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    // tick input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_arrive_valid,
    input  logic [mlfq_pkg::ID_W-1:0]          s_arrive_id,
    input  logic [mlfq_pkg::SERVICE_W-1:0]     s_arrive_service,
    // tick result
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_run_valid,
    output logic [mlfq_pkg::ID_W-1:0]          m_run_id,
    output logic [mlfq_pkg::RUN_LEVEL_W-1:0]   m_run_level,
    output logic                               m_finished,
    output logic [mlfq_pkg::STAMP_W-1:0]       m_tick_end,
    output logic                               m_arrival_rejected
);

    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(MAX_LEVEL + 1);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int TW    = mlfq_pkg::STAMP_W;
    localparam int RW    = mlfq_pkg::SERVICE_W;
    localparam int QW    = mlfq_pkg::QUANT_W;
    localparam int IW    = mlfq_pkg::ID_W;
    localparam int EW    = LW + TW + RW;
    localparam int IDX_CMP_W = 10;

    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
    localparam logic [LW-1:0] MAX_LVL  = LW'(MAX_LEVEL);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEM_RD   = 4'd1;
    localparam logic [3:0] S_DEM_WR   = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_SCAN_END = 4'd4;
    localparam logic [3:0] S_GRANT    = 4'd5;
    localparam logic [3:0] S_RUN_RD   = 4'd6;
    localparam logic [3:0] S_RUN      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic              mode_reg;
    logic [SLOTS-1:0]  busy_reg, busy_next;
    logic [CW-1:0]     busy_cnt_reg, busy_cnt_next;
    logic              holder_valid_reg, holder_valid_next;
    logic [SW-1:0]     holder_reg, holder_next;
    logic [QW-1:0]     quantum_reg, quantum_next;
    logic [TW-1:0]     tick_reg, tick_next;
    logic [SW-1:0]     scan_idx_reg, scan_idx_next;
    logic              cand_live_reg;
    logic [SW-1:0]     cand_idx_reg;
    logic              m_valid_reg, m_valid_next;

    // Per-tick result, collected while the tick is worked on.
    logic              res_run_valid_reg, res_run_valid_next;
    logic [IW-1:0]     res_id_reg, res_id_next;
    logic [2:0]        res_level_reg, res_level_next;
    logic              res_fin_reg, res_fin_next;
    logic              res_rej_reg, res_rej_next;

    // Output register payload.
    logic              out_run_valid_reg;
    logic [IW-1:0]     out_id_reg;
    logic [2:0]        out_level_reg;
    logic              out_fin_reg;
    logic [TW-1:0]     out_tick_reg;
    logic              out_rej_reg;
    logic              out_load;

    // RAM port signals.
    logic              ram_we;
    logic [SW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic [SW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;
    logic [LW-1:0]     rd_level;
    logic [TW-1:0]     rd_stamp;
    logic [RW-1:0]     rd_rem;
    logic [RW-1:0]     rem_dec;

    // Compare unit signals.
    mlfq_pkg::pick_ctl_t pick_ctl;
    logic              pick_found;
    logic [SW-1:0]     pick_idx;
    logic [LW-1:0]     pick_level;

    // Arrival decode.
    logic [SW+IW-1:0]  id_pad;
    logic [SW-1:0]     id_idx;
    logic              id_in_range;
    logic [RW-1:0]     svc_fixed;
    logic [LW+3:0]     pick_level_pad;
    logic [LW+2:0]     rd_level_pad;
    logic [SW+IW-1:0]  holder_pad;
    logic              s_accept;

    assign id_pad      = {{SW{1'b0}}, s_arrive_id};
    assign id_idx      = id_pad[SW-1:0];
    assign id_in_range = ({{(IDX_CMP_W-IW){1'b0}}, s_arrive_id} < IDX_CMP_W'(SLOTS));
    assign svc_fixed   = (s_arrive_service == '0) ? RW'(1) : s_arrive_service;
    assign s_ready     = (state_reg == S_IDLE);
    assign s_accept    = s_valid && s_ready;

    // Slot record fields: level, arrival stamp, remaining service.
    assign rd_level       = ram_rdata[EW-1 -: LW];
    assign rd_stamp       = ram_rdata[RW +: TW];
    assign rd_rem         = ram_rdata[RW-1:0];
    assign rem_dec        = rd_rem - RW'(1);
    assign pick_level_pad = {4'b0, pick_level};
    assign rd_level_pad   = {3'b0, rd_level};
    assign holder_pad     = {{IW{1'b0}}, holder_reg};

    // Compare unit control: cleared between ticks, fed one record per scan cycle.
    assign pick_ctl.clear = (state_reg == S_IDLE);
    assign pick_ctl.live  = cand_live_reg;

    mlfq_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mlfq_pick #(
        .SW (SW),
        .LW (LW)
    ) u_pick (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (pick_ctl),
        .cand_idx   (cand_idx_reg),
        .cand_level (rd_level),
        .cand_stamp (rd_stamp),
        .found      (pick_found),
        .best_idx   (pick_idx),
        .best_level (pick_level)
    );

    // Tick sequencer.
    always_comb begin
        state_next         = state_reg;
        busy_next          = busy_reg;
        busy_cnt_next      = busy_cnt_reg;
        holder_valid_next  = holder_valid_reg;
        holder_next        = holder_reg;
        quantum_next       = quantum_reg;
        tick_next          = tick_reg;
        scan_idx_next      = scan_idx_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        res_run_valid_next = res_run_valid_reg;
        res_id_next        = res_id_reg;
        res_level_next     = res_level_reg;
        res_fin_next       = res_fin_reg;
        res_rej_next       = res_rej_reg;
        out_load           = 1'b0;
        ram_we             = 1'b0;
        ram_waddr          = holder_reg;
        ram_wdata          = ram_rdata;
        ram_raddr          = holder_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_run_valid_next = 1'b0;
                    res_id_next        = '0;
                    res_level_next     = '0;
                    res_fin_next       = 1'b0;
                    res_rej_next       = 1'b0;
                    // Store the arrival at level 0, or reject it.
                    if (s_arrive_valid) begin
                        if (id_in_range && !busy_reg[id_idx]) begin
                            ram_we            = 1'b1;
                            ram_waddr         = id_idx;
                            ram_wdata         = {LW'(0), tick_reg, svc_fixed};
                            busy_next[id_idx] = 1'b1;
                            busy_cnt_next     = busy_cnt_reg + CW'(1);
                        end else begin
                            res_rej_next = 1'b1;
                        end
                    end
                    scan_idx_next = '0;
                    if (holder_valid_reg && (quantum_reg == '0)) begin
                        state_next = S_DEM_RD;
                    end else if (!holder_valid_reg) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_RUN_RD;
                    end
                end
            end
            S_DEM_RD: begin
                state_next = S_DEM_WR;
            end
            S_DEM_WR: begin
                // Demote only when some other job is waiting.
                if ((busy_cnt_reg > CW'(1)) && (rd_level < MAX_LVL)) begin
                    ram_we    = 1'b1;
                    ram_wdata = {rd_level + LW'(1), rd_stamp, rd_rem};
                end
                holder_valid_next = 1'b0;
                scan_idx_next     = '0;
                state_next        = S_SCAN;
            end
            S_SCAN: begin
                ram_raddr = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = S_SCAN_END;
                end else begin
                    scan_idx_next = scan_idx_reg + SW'(1);
                end
            end
            S_SCAN_END: begin
                state_next = S_GRANT;
            end
            S_GRANT: begin
                if (pick_found) begin
                    holder_valid_next = 1'b1;
                    holder_next       = pick_idx;
                    quantum_next      = mlfq_pkg::quantum_for(mode_reg,
                                                              pick_level_pad[3:0]);
                    state_next        = S_RUN_RD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_RUN_RD: begin
                state_next = S_RUN;
            end
            S_RUN: begin
                // The holder runs one tick.
                ram_we             = 1'b1;
                ram_wdata          = {rd_level, rd_stamp, rem_dec};
                res_run_valid_next = 1'b1;
                res_id_next        = holder_pad[IW-1:0];
                res_level_next     = rd_level_pad[2:0];
                quantum_next       = quantum_reg - QW'(1);
                if (rem_dec == '0) begin
                    res_fin_next          = 1'b1;
                    busy_next[holder_reg] = 1'b0;
                    busy_cnt_next         = busy_cnt_reg - CW'(1);
                    holder_valid_next     = 1'b0;
                    quantum_next          = '0;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    tick_next    = tick_reg + TW'(1);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            mode_reg         <= 1'b0;
            busy_reg         <= '0;
            busy_cnt_reg     <= '0;
            holder_valid_reg <= 1'b0;
            holder_reg       <= '0;
            quantum_reg      <= '0;
            tick_reg         <= '0;
            scan_idx_reg     <= '0;
            cand_live_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            busy_reg         <= busy_next;
            busy_cnt_reg     <= busy_cnt_next;
            holder_valid_reg <= holder_valid_next;
            holder_reg       <= holder_next;
            quantum_reg      <= quantum_next;
            tick_reg         <= tick_next;
            scan_idx_reg     <= scan_idx_next;
            cand_live_reg    <= (state_reg == S_SCAN) && busy_reg[scan_idx_reg];
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers: per-tick result, scan candidate tag and output stage.
    always_ff @(posedge aclk) begin
        res_run_valid_reg <= res_run_valid_next;
        res_id_reg        <= res_id_next;
        res_level_reg     <= res_level_next;
        res_fin_reg       <= res_fin_next;
        res_rej_reg       <= res_rej_next;
        cand_idx_reg      <= scan_idx_reg;
        if (out_load) begin
            out_run_valid_reg <= res_run_valid_reg;
            out_id_reg        <= res_id_reg;
            out_level_reg     <= res_level_reg;
            out_fin_reg       <= res_fin_reg;
            out_tick_reg      <= tick_reg + TW'(1);
            out_rej_reg       <= res_rej_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_run_valid        = out_run_valid_reg;
    assign m_run_id           = out_id_reg;
    assign m_run_level        = out_level_reg;
    assign m_finished         = out_fin_reg;
    assign m_tick_end         = out_tick_reg;
    assign m_arrival_rejected = out_rej_reg;

    // A held job always occupies its slot.
    a_holder_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        holder_valid_reg |-> busy_reg[holder_reg])
        else $error("holder slot is not marked busy");

    // The occupancy count tracks the busy bits.
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_cnt_reg == CW'($countones(busy_reg)))
        else $error("busy count disagrees with busy bits");

    // A finished tick waits for the output register to drain.
    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_valid_reg && !m_ready) |=> (state_reg == S_OUT))
        else $error("result overwritten while the receiver stalls");

    // One tick at a time: after a tick is taken the input closes.
    a_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("second tick accepted while one is in flight");

endmodule
